// ===== sv/vlfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlfs_pkg
// Types, codes and tables shared by the video lock / format search logic.
// ----------------------------------------------------------------------------
package vlfs_pkg;

  localparam int unsigned DWELL_W  = 16;
  localparam int unsigned FMT_W    = 3;
  localparam int unsigned STATUS_W = 8;

  localparam logic [DWELL_W-1:0] DWELL_MAX        = 16'hFFFF;
  localparam logic [DWELL_W-1:0] THRESHOLD_RESET  = 16'd50;
  localparam logic [FMT_W-1:0]   FMT_IDX_LAST     = 3'd5;
  localparam logic [FMT_W-1:0]   FMT_IDX_RESET    = 3'd1;
  localparam logic [FMT_W-1:0]   FMT_CODE_RESET   = 3'd3;   // HD30
  localparam logic               STD_CODE_RESET   = 1'b1;   // HDA

  localparam int unsigned LOSS_BIT = 7;

  // output link state codes
  localparam logic [1:0] LINK_UNPLUG = 2'd0;
  localparam logic [1:0] LINK_IN     = 2'd1;
  localparam logic [1:0] LINK_LOCKED = 2'd2;
  localparam logic [1:0] LINK_UNLOCK = 2'd3;

  // wait classes
  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_SHORT = 2'd1;
  localparam logic [1:0] WAIT_LONG  = 2'd2;

  typedef enum logic [3:0] {
    LS_UNPLUG = 4'b0001,
    LS_IN     = 4'b0010,
    LS_LOCKED = 4'b0100,
    LS_UNLOCK = 4'b1000
  } link_st_t;

  typedef struct packed {
    link_st_t           link;
    logic [DWELL_W-1:0] dwell;
    logic               std_idx;
    logic [FMT_W-1:0]   fmt_idx;
    logic [FMT_W-1:0]   cur_fmt;
    logic               cur_std;
  } vlfs_state_t;

  typedef struct packed {
    logic [DWELL_W-1:0] dwell_value;
    logic [1:0]         wait_class;
    logic               standard_code;
    logic [FMT_W-1:0]   format_code;
    logic               reinit_request;
    logic [1:0]         link_state;
  } vlfs_result_t;

  function automatic logic [1:0] link_code(input link_st_t st);
    logic [1:0] code;
    case (st)
      LS_UNPLUG: code = LINK_UNPLUG;
      LS_IN:     code = LINK_IN;
      LS_LOCKED: code = LINK_LOCKED;
      LS_UNLOCK: code = LINK_UNLOCK;
      default:   code = LINK_UNPLUG;
    endcase
    return code;
  endfunction

  // format table order: PAL, NTSC, HD30, HD25, FHD30, FHD25
  function automatic logic [FMT_W-1:0] fmt_code(input logic [FMT_W-1:0] idx);
    logic [FMT_W-1:0] code;
    case (idx)
      3'd0:    code = 3'd0;
      3'd1:    code = 3'd1;
      3'd2:    code = 3'd3;
      3'd3:    code = 3'd2;
      3'd4:    code = 3'd5;
      3'd5:    code = 3'd4;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/vlfs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlfs_step
// Next-state and result logic for one status poll.
// ----------------------------------------------------------------------------
module vlfs_step import vlfs_pkg::*; (
  input  vlfs_state_t         cur,
  input  logic [STATUS_W-1:0] status,
  input  logic [DWELL_W-1:0]  threshold,
  output vlfs_state_t         nxt,
  output vlfs_result_t        res
);

  vlfs_state_t        mid;
  logic [DWELL_W-1:0] dwell_bump;
  logic               check;
  logic               search;

  assign dwell_bump = (cur.dwell == DWELL_MAX) ? cur.dwell : cur.dwell + 1'b1;

  always_comb begin
    mid   = cur;
    check = 1'b1;
    if (status[LOSS_BIT]) begin
      mid.link  = LS_UNPLUG;
      mid.dwell = 16'd1;
    end else if (status[6] || status[5]) begin
      case (cur.link)
        LS_LOCKED: begin
          mid.dwell = dwell_bump;
          check     = 1'b0;
        end
        LS_UNPLUG: begin
          mid.link  = LS_IN;
          mid.dwell = '0;
        end
        default: begin
          mid.link  = LS_LOCKED;
          mid.dwell = '0;
        end
      endcase
    end else begin
      case (cur.link)
        LS_UNPLUG: begin
          mid.link  = LS_IN;
          mid.dwell = '0;
        end
        LS_LOCKED: begin
          mid.link  = LS_UNLOCK;
          mid.dwell = '0;
        end
        LS_IN: begin
          mid.dwell = dwell_bump;
        end
        default: begin
          mid.link  = LS_IN;
          mid.dwell = '0;
        end
      endcase
    end
  end

  // entering unlock always moves the search on
  assign search = check && ((mid.dwell >= threshold) || (mid.link == LS_UNLOCK));

  always_comb begin
    nxt = mid;
    if (search) begin
      nxt.std_idx = ~mid.std_idx;
      nxt.fmt_idx = (mid.fmt_idx >= FMT_IDX_LAST) ? '0 : mid.fmt_idx + 1'b1;
      nxt.cur_std = mid.std_idx;       // table {HDA, TVI} indexed by new index
      nxt.cur_fmt = fmt_code(nxt.fmt_idx);
      nxt.dwell   = '0;
    end
  end

  always_comb begin
    res.link_state     = link_code(nxt.link);
    res.reinit_request = search;
    res.format_code    = nxt.cur_fmt;
    res.standard_code  = nxt.cur_std;
    res.wait_class     = !check ? WAIT_NONE : (search ? WAIT_LONG : WAIT_SHORT);
    res.dwell_value    = nxt.dwell;
  end

endmodule

// ===== sv/video_lock_format_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_lock_format_search_core
// Link watchdog that steps through video formats and standards until lock.
// ----------------------------------------------------------------------------
// Takes one status word per cycle and returns one result word per status word,
// in the cycle after acceptance. The poll is evaluated by a short block of logic
// from the link state registers straight into a single output register, so
// input and output run at one word per clock; in_tready drops only while a
// result sits in the output register and out_tready is low. search_threshold
// is written through cfg_wr_en/cfg_wr_data and should change only when idle.
module video_lock_format_search_core import vlfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,     // search_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,        // [7:0] status_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata        // [1:0] link_state, [2] reinit_request,
                                       // [5:3] format_code, [6] standard_code,
                                       // [8:7] wait_class, [24:9] dwell_value
);

  vlfs_state_t        st_r, st_nxt;
  vlfs_result_t       res_r, res_nxt;
  logic [DWELL_W-1:0] threshold_r;
  logic               out_valid_r;
  logic               in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  vlfs_step u_step (
    .cur       (st_r),
    .status    (in_tdata),
    .threshold (threshold_r),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      st_r.link    <= LS_UNPLUG;
      st_r.dwell   <= '0;
      st_r.std_idx <= 1'b0;
      st_r.fmt_idx <= FMT_IDX_RESET;
      st_r.cur_fmt <= FMT_CODE_RESET;
      st_r.cur_std <= STD_CODE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      if (in_acc) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r};

endmodule

// ===== sv/vlfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlfs_checker
// Port-level checks on the result stream of the lock / search core.
// ----------------------------------------------------------------------------
module vlfs_checker import vlfs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic [1:0] link_f;
  logic       reinit_f;
  logic [1:0] wait_f;
  logic [15:0] dwell_f;

  assign link_f   = out_tdata[1:0];
  assign reinit_f = out_tdata[2];
  assign wait_f   = out_tdata[8:7];
  assign dwell_f  = out_tdata[24:9];

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // a re-init always comes with the long wait, and only then
  a_reinit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (reinit_f == (wait_f == WAIT_LONG)))
    else $error("reinit and wait class disagree");

  // a new search restarts the dwell count
  a_reinit_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && reinit_f |-> dwell_f == 16'd0)
    else $error("dwell not cleared on reinit");

  // no wait only for a link that stays locked
  a_none_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (wait_f == WAIT_NONE) |-> link_f == LINK_LOCKED)
    else $error("wait none outside locked state");

  // entering unlock always starts a search
  a_unlock_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (link_f == LINK_UNLOCK) |-> reinit_f)
    else $error("unlock without reinit");

endmodule

bind video_lock_format_search_core vlfs_checker u_vlfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/video_lock_format_search_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_lock_format_search_core_test
// Drives status words through the link watchdog and checks each result word
// against a cycle-free model of the lock machine and the format/standard
// search. A short directed table is followed by random runs under several
// search thresholds and idle patterns.
// ----------------------------------------------------------------------------
module video_lock_format_search_core_test;
  import vlfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam logic [7:0] LOSS_MASK = 8'h80;
  localparam logic [7:0] LOCK_MASK = 8'h60;

  localparam logic [2:0] FMT_PAL   = 3'd0;
  localparam logic [2:0] FMT_NTSC  = 3'd1;
  localparam logic [2:0] FMT_HD25  = 3'd2;
  localparam logic [2:0] FMT_HD30  = 3'd3;
  localparam logic [2:0] FMT_FHD25 = 3'd4;
  localparam logic [2:0] FMT_FHD30 = 3'd5;
  localparam logic       STD_TVI   = 1'b0;
  localparam logic       STD_HDA   = 1'b1;

  // search order of the two round-robin tables
  localparam logic [2:0] FMT_BY_POS [0:5] =
    '{FMT_PAL, FMT_NTSC, FMT_HD30, FMT_HD25, FMT_FHD30, FMT_FHD25};
  localparam logic STD_BY_POS [0:1] = '{STD_HDA, STD_TVI};

  localparam vlfs_result_t NO_RESULT = '0;

  typedef enum logic [1:0] {
    ROW_POLL,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [15:0]  value;
    logic         typed;
    vlfs_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;        // [7:0] status_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [1:0] link_state, [2] reinit_request,
                                     // [5:3] format_code, [6] standard_code,
                                     // [8:7] wait_class, [24:9] dwell_value

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // model state of the watchdog
  logic [1:0]  link_now = LINK_UNPLUG;
  logic [15:0] dwell_now = '0;
  logic        std_pos = 1'b0;
  logic [2:0]  fmt_pos = FMT_IDX_RESET;
  logic [2:0]  fmt_now = FMT_CODE_RESET;
  logic        std_now = STD_CODE_RESET;
  logic [15:0] search_limit = THRESHOLD_RESET;

  vlfs_result_t results_due [$];
  vlfs_result_t got_word, due_word;
  dir_row_t     directed_rows [0:25];

  video_lock_format_search_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic vlfs_result_t shaped(input logic [1:0] link, input logic reinit,
                                          input logic [2:0] fmt, input logic std,
                                          input logic [1:0] wt, input logic [15:0] dwell);
    vlfs_result_t r;
    r.link_state     = link;
    r.reinit_request = reinit;
    r.format_code    = fmt;
    r.standard_code  = std;
    r.wait_class     = wt;
    r.dwell_value    = dwell;
    return r;
  endfunction

  function automatic vlfs_result_t poll_outcome(input logic [7:0] status);
    vlfs_result_t res;
    logic         settled;
    res = '0;
    settled = 1'b0;
    if ((status & LOSS_MASK) != 0) begin
      link_now = LINK_UNPLUG;
      dwell_now = 16'd1;
    end else if ((status & LOCK_MASK) != 0) begin
      case (link_now)
        LINK_LOCKED: begin
          if (dwell_now != DWELL_MAX) dwell_now = dwell_now + 1'b1;
          settled = 1'b1;
        end
        LINK_UNPLUG: begin
          link_now = LINK_IN;
          dwell_now = '0;
        end
        default: begin
          link_now = LINK_LOCKED;
          dwell_now = '0;
        end
      endcase
    end else begin
      case (link_now)
        LINK_UNPLUG: begin
          link_now = LINK_IN;
          dwell_now = '0;
        end
        LINK_LOCKED: begin
          link_now = LINK_UNLOCK;
          dwell_now = '0;
        end
        default: begin
          if (dwell_now != DWELL_MAX) dwell_now = dwell_now + 1'b1;
          // unlock falls back to in with a fresh dwell
          if (link_now == LINK_UNLOCK) begin
            link_now = LINK_IN;
            dwell_now = '0;
          end
        end
      endcase
    end

    if (settled) begin
      res.wait_class = WAIT_NONE;
    end else if (dwell_now < search_limit && link_now != LINK_UNLOCK) begin
      res.wait_class = WAIT_SHORT;
    end else begin
      // both tables step together
      std_pos = ~std_pos;
      fmt_pos = (fmt_pos == FMT_IDX_LAST) ? 3'd0 : fmt_pos + 3'd1;
      std_now = STD_BY_POS[std_pos];
      fmt_now = FMT_BY_POS[fmt_pos];
      dwell_now = '0;
      res.reinit_request = 1'b1;
      res.wait_class = WAIT_LONG;
    end
    res.link_state = link_now;
    res.format_code = fmt_now;
    res.standard_code = std_now;
    res.dwell_value = dwell_now;
    return res;
  endfunction

  task automatic push_status(input logic [7:0] status, input logic typed,
                             input vlfs_result_t want);
    vlfs_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= status;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = poll_outcome(status);
    results_due.push_back(typed ? want : predicted);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_search_limit(input logic [15:0] value);
    wait_results_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    search_limit = value;
  endtask

  // runs of one kind of status so that dwell and lock get somewhere
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 12);
      for (k = 0; k < len && sent < count; k++) begin
        b = 8'($urandom);
        if (pick < 10) begin
          b = b;                        // noise word
        end else if (pick < 20) begin
          b[7] = 1'b1;
        end else if (pick < 60) begin
          b[7] = 1'b0;
          if (b[6:5] == 2'b00) b[6:5] = 2'($urandom_range(1, 3));
        end else begin
          b[7:5] = 3'b000;
        end
        push_status(b, 1'b0, NO_RESULT);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        mismatch_count++;
      end else begin
        due_word = results_due.pop_front();
        got_word = out_tdata[24:0];
        if (out_tdata[31:25] !== 7'd0) begin
          $error("pad: expected %0d, got %0d", 0, out_tdata[31:25]);
          mismatch_count++;
        end
        if (got_word.link_state !== due_word.link_state) begin
          $error("link_state: expected %0d, got %0d", due_word.link_state,
                 got_word.link_state);
          mismatch_count++;
        end
        if (got_word.reinit_request !== due_word.reinit_request) begin
          $error("reinit_request: expected %0d, got %0d", due_word.reinit_request,
                 got_word.reinit_request);
          mismatch_count++;
        end
        if (got_word.format_code !== due_word.format_code) begin
          $error("format_code: expected %0d, got %0d", due_word.format_code,
                 got_word.format_code);
          mismatch_count++;
        end
        if (got_word.standard_code !== due_word.standard_code) begin
          $error("standard_code: expected %0d, got %0d", due_word.standard_code,
                 got_word.standard_code);
          mismatch_count++;
        end
        if (got_word.wait_class !== due_word.wait_class) begin
          $error("wait_class: expected %0d, got %0d", due_word.wait_class,
                 got_word.wait_class);
          mismatch_count++;
        end
        if (got_word.dwell_value !== due_word.dwell_value) begin
          $error("dwell_value: expected %0d, got %0d", due_word.dwell_value,
                 got_word.dwell_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    directed_rows = '{
      // after reset, threshold 50
      '{ROW_POLL, 16'h0000, 1'b1, shaped(LINK_IN, 1'b0, FMT_HD30, STD_HDA, WAIT_SHORT, 16'd0)},
      '{ROW_POLL, 16'h00FF, 1'b1,
        shaped(LINK_UNPLUG, 1'b0, FMT_HD30, STD_HDA, WAIT_SHORT, 16'd1)},
      '{ROW_POLL, 16'h0020, 1'b1, shaped(LINK_IN, 1'b0, FMT_HD30, STD_HDA, WAIT_SHORT, 16'd0)},
      '{ROW_POLL, 16'h0040, 1'b1,
        shaped(LINK_LOCKED, 1'b0, FMT_HD30, STD_HDA, WAIT_SHORT, 16'd0)},
      '{ROW_POLL, 16'h0060, 1'b1,
        shaped(LINK_LOCKED, 1'b0, FMT_HD30, STD_HDA, WAIT_NONE, 16'd1)},
      // lock lost: search starts with link state unlock, then falls back to in
      '{ROW_POLL, 16'h001F, 1'b1,
        shaped(LINK_UNLOCK, 1'b1, FMT_HD30, STD_TVI, WAIT_LONG, 16'd0)},
      '{ROW_POLL, 16'h0000, 1'b1, shaped(LINK_IN, 1'b0, FMT_HD30, STD_TVI, WAIT_SHORT, 16'd0)},
      '{ROW_POLL, 16'h007F, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h009E, 1'b0, NO_RESULT},
      // threshold 1: loss alone now starts a search, then index wrap
      '{ROW_CFG,  16'd1,    1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0080, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0020, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0040, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0001, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0001, 1'b0, NO_RESULT},
      // threshold zero: everything but locked-while-locked searches
      '{ROW_CFG,  16'd0,    1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0060, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0060, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_CFG,  16'hFFFF, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_POLL, 16'h00E0, 1'b0, NO_RESULT}
    };

    send_idle_pct = 33;
    recv_idle_pct = 87;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 26; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_search_limit(directed_rows[i].value);
      end else begin
        push_status(directed_rows[i].value[7:0], directed_rows[i].typed,
                    directed_rows[i].want);
      end
    end

    set_search_limit(16'($urandom_range(1, 6)));
    run_random(450);

    send_idle_pct = 87;
    recv_idle_pct = 33;
    set_search_limit(16'($urandom_range(4, 16)));
    run_random(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_search_limit(16'($urandom_range(1, 10)));
    run_random(450);

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
